// ===== rtl/trkl_pkg.sv =====
// ----------------------------------------------------------------------------
// trkl_pkg: shared types and constants of the trickle timer
// Field widths, register map, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package trkl_pkg;

  localparam int TimeBits  = 48;
  localparam int OutW      = 48;
  localparam int KindW     = 2;
  localparam int DrawW     = 24;
  localparam int IntervalW = 24;
  localparam int LenW      = IntervalW + 1;
  localparam int HalfW     = IntervalW - 1;
  localparam int KW        = 8;
  localparam int CountW    = 8;
  localparam int RemCntW   = $clog2(DrawW + 1);

  localparam int DataW     = 32;
  localparam int NumRegs   = 5;
  localparam int AddrW     = $clog2(4 * NumRegs);
  localparam int IdxW      = AddrW - 2;

  localparam logic [IdxW-1:0] RegIntervalMin   = IdxW'(0);
  localparam logic [IdxW-1:0] RegIntervalMax   = IdxW'(1);
  localparam logic [IdxW-1:0] RegRedundancyK   = IdxW'(2);
  localparam logic [IdxW-1:0] RegKeepaliveMs   = IdxW'(3);
  localparam logic [IdxW-1:0] RegReliable      = IdxW'(4);

  localparam logic [IntervalW-1:0] IntervalMinRst = IntervalW'(200);
  localparam logic [IntervalW-1:0] IntervalMaxRst = IntervalW'(40000);
  localparam logic [KW-1:0]        RedundancyKRst = KW'(1);
  localparam logic [IntervalW-1:0] KeepaliveRst   = IntervalW'(20000);

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [KindW-1:0] {
    KindTimeout    = 2'd0,
    KindReset      = 2'd1,
    KindStart      = 2'd2,
    KindConsistent = 2'd3
  } trkl_kind_e;

  typedef struct packed {
    logic [IntervalW-1:0] interval_min;
    logic [IntervalW-1:0] interval_max;
    logic [KW-1:0]        redundancy_k;
    logic [IntervalW-1:0] keepalive_ms;
    logic                 reliable_stream;
  } trkl_cfg_t;

endpackage

// ===== rtl/trkl_cfg.sv =====
// ----------------------------------------------------------------------------
// trkl_cfg: configuration registers
// APB-style register file holding the interval bounds, k, keepalive and the reliable-stream flag.
// ----------------------------------------------------------------------------
module trkl_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trkl_pkg::AddrW-1:0]   paddr,
  input  logic [trkl_pkg::DataW-1:0]   pwdata,
  output logic [trkl_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output trkl_pkg::trkl_cfg_t          cfg_o
);
  import trkl_pkg::*;

  trkl_cfg_t       cfg_q, cfg_d;
  logic [IdxW-1:0] idx;
  logic            wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegIntervalMin: cfg_d.interval_min    = pwdata[IntervalW-1:0];
        RegIntervalMax: cfg_d.interval_max    = pwdata[IntervalW-1:0];
        RegRedundancyK: cfg_d.redundancy_k    = pwdata[KW-1:0];
        RegKeepaliveMs: cfg_d.keepalive_ms    = pwdata[IntervalW-1:0];
        RegReliable:    cfg_d.reliable_stream = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegIntervalMin: prdata = DataW'(cfg_q.interval_min);
      RegIntervalMax: prdata = DataW'(cfg_q.interval_max);
      RegRedundancyK: prdata = DataW'(cfg_q.redundancy_k);
      RegKeepaliveMs: prdata = DataW'(cfg_q.keepalive_ms);
      RegReliable:    prdata = DataW'(cfg_q.reliable_stream);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_min    <= IntervalMinRst;
      cfg_q.interval_max    <= IntervalMaxRst;
      cfg_q.redundancy_k    <= RedundancyKRst;
      cfg_q.keepalive_ms    <= KeepaliveRst;
      cfg_q.reliable_stream <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/trkl_rem.sv =====
// ----------------------------------------------------------------------------
// trkl_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; yields dividend mod divisor.
// ----------------------------------------------------------------------------
module trkl_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [trkl_pkg::DrawW-1:0]  dividend_i,
  input  logic [trkl_pkg::HalfW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [trkl_pkg::HalfW-1:0]  rem_o
);
  import trkl_pkg::*;

  logic [DrawW-1:0]   dvd_q, dvd_d;
  logic [HalfW-1:0]   div_q, div_d;
  logic [HalfW-1:0]   rem_q, rem_d;
  logic [RemCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [HalfW:0]     trial;

  assign trial = {rem_q, dvd_q[DrawW-1]};

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = RemCntW'(DrawW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      dvd_d = {dvd_q[DrawW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = HalfW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[HalfW-1:0];
      end
      cnt_d = cnt_q - RemCntW'(1);
      if (cnt_q == RemCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // a zero divisor means no random term
  assign rem_o  = (div_q == '0) ? '0 : rem_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

endmodule

// ===== rtl/trickle_timer_with_keepalive_top.sv =====
// ----------------------------------------------------------------------------
// trickle_timer_with_keepalive_top: Trickle timer with keepalive
// Consistent-heard goes straight to the deadline scan; a timeout checks the
// keepalive, then interval end and send point; reset and start draw anew. A
// draw sets the interval, runs the remainder unit and adds the send point.
// One event is processed at a time; the next is taken once the result is
// registered. Reset restores the register defaults and clears the timer state.
// ----------------------------------------------------------------------------
module trickle_timer_with_keepalive_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [trkl_pkg::KindW-1:0]    kind_i,
  input  logic [trkl_pkg::TimeBits-1:0] now_i,
  input  logic [trkl_pkg::DrawW-1:0]    random_draw_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          send_now_o,
  output logic                          short_form_o,
  output logic                          suppressed_o,
  output logic [trkl_pkg::OutW-1:0]     next_deadline_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trkl_pkg::AddrW-1:0]    paddr,
  input  logic [trkl_pkg::DataW-1:0]    pwdata,
  output logic [trkl_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import trkl_pkg::*;

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StKa     = 10'b0000000010,
    StSetInt = 10'b0000000100,
    StDiv    = 10'b0000001000,
    StSpAdd  = 10'b0000010000,
    StPh2    = 10'b0000100000,
    StDl1    = 10'b0001000000,
    StDl2    = 10'b0010000000,
    StDl3    = 10'b0100000000,
    StDone   = 10'b1000000000
  } trkl_state_e;

  trkl_state_e state_q, state_d;
  trkl_cfg_t   cfg;

  // timer state
  logic [IntervalW-1:0] ilen_q, ilen_d;
  logic [TimeBits-1:0]  sp_q, sp_d;
  logic [TimeBits-1:0]  ie_q, ie_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [TimeBits-1:0]  lst_q, lst_d;
  logic                 ret_ph2_q, ret_ph2_d;
  logic                 out_valid_q, out_valid_d;

  // working registers
  logic [TimeBits-1:0]  now_q, now_d;
  logic [DrawW-1:0]     draw_q, draw_d;
  logic [LenW-1:0]      len_arg_q, len_arg_d;
  logic [TimeBits-1:0]  best_q, best_d;
  logic                 sent_q, sent_d;
  logic                 shortf_q, shortf_d;
  logic                 supp_q, supp_d;
  logic                 o_send_q, o_send_d;
  logic                 o_short_q, o_short_d;
  logic                 o_supp_q, o_supp_d;
  logic [OutW-1:0]      o_next_q, o_next_d;

  logic [TimeBits-1:0]  ka_t;
  logic                 ka_on;
  logic [IntervalW-1:0] len_clamp;
  logic [HalfW-1:0]     half;
  logic [HalfW-1:0]     rem;
  logic                 rem_done;
  logic [IntervalW-1:0] half_plus;
  logic                 ilen_is_min;
  logic                 send_ok;

  trkl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  trkl_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StSetInt),
    .dividend_i (draw_q),
    .divisor_i  (len_clamp[IntervalW-1:1]),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  assign ka_on = cfg.keepalive_ms != '0;
  assign ka_t  = lst_q + TimeBits'(cfg.keepalive_ms);

  // when the bounds cross, the lower bound wins for arguments below it, else the upper
  always_comb begin
    if (len_arg_q < LenW'(cfg.interval_min)) begin
      len_clamp = cfg.interval_min;
    end else if (len_arg_q > LenW'(cfg.interval_max)) begin
      len_clamp = cfg.interval_max;
    end else begin
      len_clamp = len_arg_q[IntervalW-1:0];
    end
  end

  assign half        = ilen_q[IntervalW-1:1];
  assign half_plus   = IntervalW'(half) + IntervalW'(rem);
  assign ilen_is_min = ilen_q == cfg.interval_min;
  assign send_ok     = (cnt_q < cfg.redundancy_k) && (!cfg.reliable_stream || ilen_is_min);

  assign in_ready_o = state_q == StIdle;

  always_comb begin
    state_d     = state_q;
    ilen_d      = ilen_q;
    sp_d        = sp_q;
    ie_d        = ie_q;
    cnt_d       = cnt_q;
    lst_d       = lst_q;
    ret_ph2_d   = ret_ph2_q;
    now_d       = now_q;
    draw_d      = draw_q;
    len_arg_d   = len_arg_q;
    best_d      = best_q;
    sent_d      = sent_q;
    shortf_d    = shortf_q;
    supp_d      = supp_q;
    o_send_d    = o_send_q;
    o_short_d   = o_short_q;
    o_supp_d    = o_supp_q;
    o_next_d    = o_next_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          now_d     = now_i;
          draw_d    = random_draw_i;
          sent_d    = 1'b0;
          shortf_d  = 1'b0;
          supp_d    = 1'b0;
          ret_ph2_d = 1'b0;
          len_arg_d = LenW'(cfg.interval_min);
          unique case (trkl_kind_e'(kind_i))
            KindTimeout: state_d = StKa;
            KindReset:   state_d = StSetInt;
            KindStart: begin
              lst_d   = now_i;
              state_d = StSetInt;
            end
            KindConsistent: begin
              if (cnt_q != CountMax) begin
                cnt_d = cnt_q + CountW'(1);
              end
              state_d = StDl1;
            end
            default: state_d = StDl1;
          endcase
        end
      end
      StKa: begin
        if (ka_on && (ka_t <= now_q)) begin
          sent_d    = 1'b1;
          shortf_d  = !ilen_is_min;
          lst_d     = now_q;
          len_arg_d = LenW'(ilen_q);
          ret_ph2_d = 1'b1;
          state_d   = StSetInt;
        end else begin
          state_d = StPh2;
        end
      end
      StSetInt: begin
        ilen_d  = len_clamp;
        state_d = StDiv;
      end
      StDiv: begin
        if (rem_done) begin
          state_d = StSpAdd;
        end
      end
      StSpAdd: begin
        sp_d    = now_q + TimeBits'(half_plus);
        ie_d    = now_q + TimeBits'(ilen_q);
        cnt_d   = '0;
        state_d = ret_ph2_q ? StPh2 : StDl1;
      end
      StPh2: begin
        ret_ph2_d = 1'b0;
        if (ie_q <= now_q) begin
          // interval over: double and redraw
          len_arg_d = {ilen_q, 1'b0};
          state_d   = StSetInt;
        end else begin
          if (sp_q != '0 && sp_q <= now_q) begin
            if (send_ok) begin
              sent_d   = 1'b1;
              shortf_d = !ilen_is_min;
              lst_d    = now_q;
            end else begin
              supp_d = 1'b1;
            end
            sp_d = '0;
          end
          state_d = StDl1;
        end
      end
      StDl1: begin
        best_d  = ka_on ? ka_t : '0;
        state_d = StDl2;
      end
      StDl2: begin
        if (ie_q != '0 && (best_q == '0 || ie_q < best_q)) begin
          best_d = ie_q;
        end
        state_d = StDl3;
      end
      StDl3: begin
        if (sp_q != '0 && (best_q == '0 || sp_q < best_q)) begin
          best_d = sp_q;
        end
        state_d = StDone;
      end
      StDone: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          o_send_d    = sent_q;
          o_short_d   = shortf_q;
          o_supp_d    = supp_q;
          o_next_d    = OutW'(best_q);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ilen_q      <= IntervalMinRst;
      sp_q        <= '0;
      ie_q        <= '0;
      cnt_q       <= '0;
      lst_q       <= '0;
      ret_ph2_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ilen_q      <= ilen_d;
      sp_q        <= sp_d;
      ie_q        <= ie_d;
      cnt_q       <= cnt_d;
      lst_q       <= lst_d;
      ret_ph2_q   <= ret_ph2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    draw_q    <= draw_d;
    len_arg_q <= len_arg_d;
    best_q    <= best_d;
    sent_q    <= sent_d;
    shortf_q  <= shortf_d;
    supp_q    <= supp_d;
    o_send_q  <= o_send_d;
    o_short_q <= o_short_d;
    o_supp_q  <= o_supp_d;
    o_next_q  <= o_next_d;
  end

  assign out_valid_o     = out_valid_q;
  assign send_now_o      = o_send_q;
  assign short_form_o    = o_short_q;
  assign suppressed_o    = o_supp_q;
  assign next_deadline_o = o_next_q;

endmodule

// ===== rtl/trkl_chk.sv =====
// ----------------------------------------------------------------------------
// trkl_chk: port-level checks of the trickle timer
// Watches the event and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module trkl_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      send_now_o,
  input logic                      short_form_o,
  input logic [trkl_pkg::OutW-1:0] next_deadline_o
);
  import trkl_pkg::*;

  // short form only describes a message that went out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && short_form_o |-> send_now_o)
    else $error("short_form without send_now");

  // an accepted request keeps the block busy through the deadline scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##4 !in_ready_o)
    else $error("request accepted too soon after the previous one");

  // readiness drops in the cycle after a request is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after accepting a request");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_deadline_o)
      && $stable(send_now_o))
    else $error("stalled result changed");

endmodule

bind trickle_timer_with_keepalive_top trkl_chk u_trkl_chk (.*);
